// ===== src/gcb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants for the glyph coverage blend frame block.
// ----------------------------------------------------------------------------
package gcb_pkg;

  // Frame store geometry; pixel (x, y) lives at {y, x}
  localparam int MAX_FRAME_WIDTH  = 1024;
  localparam int MAX_FRAME_HEIGHT = 128;
  localparam int BASELINE         = 32;

  localparam int XW    = $clog2(MAX_FRAME_WIDTH);
  localparam int YW    = $clog2(MAX_FRAME_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;

  // Signed coordinate widths: room for origin plus bearing plus glyph offset
  localparam int CXW = ((XW > 9) ? XW : 9) + 2;
  localparam int CYW = ((YW > 8) ? YW : 8) + 2;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int FW_W   = 11;
  localparam int FH_W   = 8;

  // Stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    CMD_BLEND = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PENCIL_R = 3'd0,
    REG_PENCIL_G = 3'd1,
    REG_PENCIL_B = 3'd2,
    REG_FILL_R   = 3'd3,
    REG_FILL_G   = 3'd4,
    REG_FILL_B   = 3'd5,
    REG_FRAME_W  = 3'd6,
    REG_FRAME_H  = 3'd7
  } reg_idx_e;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  typedef struct packed {
    rgb_t            pencil;
    rgb_t            fill;
    logic [FW_W-1:0] frame_width;
    logic [FH_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] origin_x;
    logic [6:0] origin_y;
    logic [7:0] bear_x;
    logic [7:0] bear_y;
    logic [5:0] glyph_col;
    logic [5:0] glyph_row;
    logic [7:0] coverage;
  } item_t;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    rgb_t          wdata;
  } mem_req_t;

  localparam chan_t PENCIL_RST  = 8'd255;
  localparam chan_t FILL_RST    = 8'd0;
  localparam logic [FW_W-1:0] FRAME_W_RST = 11'd900;
  localparam logic [FH_W-1:0] FRAME_H_RST = 8'd72;

endpackage

// ===== src/glyph_coverage_blend_to_rgb_frame.sv =====
// ----------------------------------------------------------------------------
// glyph_coverage_blend_to_rgb_frame
// Blends glyph coverage pixels, fills and reads pixels of an RGB888 frame.
//
//   channel   direction  payload (low bit first)
//   s_axis    in         tuser: cmd[1:0]; tdata: origin_x, origin_y, bear_x,
//                        bear_y, glyph_col, glyph_row, coverage
//   m_axis    out        tuser: in_frame; tdata: red, green, blue
//   apb       in/out     pencil rgb, fill rgb, frame_width, frame_height
//
// An item is accepted only when the sequencer is idle, so the next item waits
// until the last one completes. The steps are set by the single frame memory
// port: address, read, mix, divide, then write back.
// After reset the memory clearing pass writes all 131072 pixels (one pixel a
// cycle) with s_axis_tready low; APB writes are taken meanwhile.
// A stalled result holds in the output register; the next item is accepted
// and worked up to its write-back, which waits for the register to free.
// ----------------------------------------------------------------------------
module glyph_coverage_blend_to_rgb_frame (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tuser: cmd[1:0]
  input  logic [gcb_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // tdata: origin_x[9:0], origin_y[16:10], bear_x[24:17], bear_y[32:25],
  //        glyph_col[38:33], glyph_row[44:39], coverage[52:45], zero[55:53]
  input  logic [gcb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tuser: in_frame[0]
  output logic                             m_axis_tuser,
  // tdata: red[7:0], green[15:8], blue[23:16]
  output logic [gcb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gcb_pkg::CFG_AW-1:0]       paddr,
  input  logic [gcb_pkg::CFG_DW-1:0]       pwdata,
  output logic [gcb_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);
  import gcb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  state_e         state_q;
  item_t          item_q;
  logic [AW-1:0]  addr_q;
  logic           inframe_q;
  logic           out_valid_q;
  logic           out_inframe_q;
  rgb_t           out_rgb_q;

  cfg_t           cfg;
  mem_req_t       mem_req;
  rgb_t           mem_rdata;
  rgb_t           mix;
  logic           clr_busy;

  item_t          in_item;
  logic           in_fire;
  logic           done_fire;
  logic           is_blend;
  logic           is_write;
  logic [CXW-1:0] x_blend;
  logic [CXW-1:0] x;
  logic [CYW-1:0] y_blend;
  logic [CYW-1:0] y;
  logic [CXW-1:0] fw_raw;
  logic [CXW-1:0] fw_eff;
  logic [CYW-1:0] fh_raw;
  logic [CYW-1:0] fh_eff;
  logic           inframe;
  rgb_t           result;

  gcb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gcb_frame_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  gcb_blend u_blend (
    .clk_i (clk_i),
    .bg_i  (mem_rdata),
    .pen_i (cfg.pencil),
    .cov_i (item_q.coverage),
    .mix_o (mix)
  );

  // Unpack the input transaction
  assign in_item.cmd       = s_axis_tuser;
  assign in_item.origin_x  = s_axis_tdata[9:0];
  assign in_item.origin_y  = s_axis_tdata[16:10];
  assign in_item.bear_x    = s_axis_tdata[24:17];
  assign in_item.bear_y    = s_axis_tdata[32:25];
  assign in_item.glyph_col = s_axis_tdata[38:33];
  assign in_item.glyph_row = s_axis_tdata[44:39];
  assign in_item.coverage  = s_axis_tdata[52:45];

  assign s_axis_tready = (state_q == S_IDLE) && !clr_busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign done_fire     = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign is_blend      = (item_q.cmd == CMD_BLEND);
  assign is_write      = is_blend || (item_q.cmd == CMD_FILL);

  // Target coordinate; blend adds bear_x, the baseline and glyph offsets, less bear_y
  assign x_blend = {{(CXW-10){1'b0}}, item_q.origin_x}
                 + {{(CXW-8){item_q.bear_x[7]}}, item_q.bear_x}
                 + {{(CXW-6){1'b0}}, item_q.glyph_col};
  assign y_blend = {{(CYW-7){1'b0}}, item_q.origin_y}
                 + CYW'(BASELINE)
                 - {{(CYW-8){item_q.bear_y[7]}}, item_q.bear_y}
                 + {{(CYW-6){1'b0}}, item_q.glyph_row};
  assign x = is_blend ? x_blend : {{(CXW-10){1'b0}}, item_q.origin_x};
  assign y = is_blend ? y_blend : {{(CYW-7){1'b0}}, item_q.origin_y};

  // Active frame, clamped to the store size
  assign fw_raw  = CXW'(cfg.frame_width);
  assign fh_raw  = CYW'(cfg.frame_height);
  assign fw_eff  = (fw_raw > CXW'(MAX_FRAME_WIDTH)) ? CXW'(MAX_FRAME_WIDTH) : fw_raw;
  assign fh_eff  = (fh_raw > CYW'(MAX_FRAME_HEIGHT)) ? CYW'(MAX_FRAME_HEIGHT) : fh_raw;
  assign inframe = !x[CXW-1] && (x < fw_eff) && !y[CYW-1] && (y < fh_eff);

  // Pixel value after the operation
  always_comb begin
    case (item_q.cmd)
      CMD_BLEND: result = mix;
      CMD_FILL:  result = cfg.fill;
      default:   result = mem_rdata;
    endcase
  end

  // Memory port: read in S_READ, write back on completion
  assign mem_req.re    = (state_q == S_READ) && inframe_q;
  assign mem_req.we    = done_fire && inframe_q && is_write;
  assign mem_req.addr  = addr_q;
  assign mem_req.wdata = result;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      item_q        <= '0;
      addr_q        <= '0;
      inframe_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_inframe_q <= 1'b0;
      out_rgb_q     <= '0;
    end else begin
      // a completion in the same cycle refills the register below
      if (out_valid_q && m_axis_tready && !done_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            item_q  <= in_item;
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr_q    <= {y[YW-1:0], x[XW-1:0]};
          inframe_q <= inframe;
          state_q   <= S_READ;
        end
        S_READ: state_q <= S_MUL;
        S_MUL:  state_q <= S_DIV;
        S_DIV:  state_q <= S_DONE;
        S_DONE: begin
          if (done_fire) begin
            out_valid_q   <= 1'b1;
            out_inframe_q <= inframe_q;
            out_rgb_q     <= inframe_q ? result : '0;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_inframe_q;
  assign m_axis_tdata  = {out_rgb_q.b, out_rgb_q.g, out_rgb_q.r};

  // No item enters while the clearing pass owns the memory
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready)
    else $error("item accepted during memory clear");

  // Dropped pixels report black
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out-of-frame result carries pixel data");

  // Write-back waits while a stalled result occupies the output register
  a_done_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && m_axis_tvalid && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("completion overran a stalled result");

  // An accepted item starts address generation next cycle
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == S_ADDR))
    else $error("accepted item did not start");

endmodule

// ===== src/gcb_regs.sv =====
// ----------------------------------------------------------------------------
// gcb_regs
// APB-style configuration registers: pencil color, fill color, frame size.
// ----------------------------------------------------------------------------
module gcb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcb_pkg::CFG_AW-1:0]  paddr,
  input  logic [gcb_pkg::CFG_DW-1:0]  pwdata,
  output logic [gcb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output gcb_pkg::cfg_t               cfg_o
);
  import gcb_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pencil       <= '{r: PENCIL_RST, g: PENCIL_RST, b: PENCIL_RST};
      cfg_q.fill         <= '{r: FILL_RST, g: FILL_RST, b: FILL_RST};
      cfg_q.frame_width  <= FRAME_W_RST;
      cfg_q.frame_height <= FRAME_H_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PENCIL_R: cfg_q.pencil.r     <= pwdata[7:0];
        REG_PENCIL_G: cfg_q.pencil.g     <= pwdata[7:0];
        REG_PENCIL_B: cfg_q.pencil.b     <= pwdata[7:0];
        REG_FILL_R:   cfg_q.fill.r       <= pwdata[7:0];
        REG_FILL_G:   cfg_q.fill.g       <= pwdata[7:0];
        REG_FILL_B:   cfg_q.fill.b       <= pwdata[7:0];
        REG_FRAME_W:  cfg_q.frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_H:  cfg_q.frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PENCIL_R: prdata = CFG_DW'(cfg_q.pencil.r);
      REG_PENCIL_G: prdata = CFG_DW'(cfg_q.pencil.g);
      REG_PENCIL_B: prdata = CFG_DW'(cfg_q.pencil.b);
      REG_FILL_R:   prdata = CFG_DW'(cfg_q.fill.r);
      REG_FILL_G:   prdata = CFG_DW'(cfg_q.fill.g);
      REG_FILL_B:   prdata = CFG_DW'(cfg_q.fill.b);
      REG_FRAME_W:  prdata = CFG_DW'(cfg_q.frame_width);
      REG_FRAME_H:  prdata = CFG_DW'(cfg_q.frame_height);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== src/gcb_frame_mem.sv =====
// ----------------------------------------------------------------------------
// gcb_frame_mem
// RGB888 frame store: one port, registered read data, clearing pass at reset.
// ----------------------------------------------------------------------------
module gcb_frame_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcb_pkg::mem_req_t req_i,
  output gcb_pkg::rgb_t     rdata_o,
  output logic              clr_busy_o
);
  import gcb_pkg::*;

  rgb_t          mem [DEPTH];
  rgb_t          rdata_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  logic          we;
  logic [AW-1:0] waddr;
  rgb_t          wdata;

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

  // Clearing sweep owns the write port right after reset
  assign we    = clr_busy_q || req_i.we;
  assign waddr = clr_busy_q ? clr_addr_q : req_i.addr;
  assign wdata = clr_busy_q ? '0 : req_i.wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (&clr_addr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Storage array
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

endmodule

// ===== src/gcb_blend.sv =====
// ----------------------------------------------------------------------------
// gcb_blend
// Three-lane coverage mix ((255-h)*bg + h*pen)/255 in two register stages.
// ----------------------------------------------------------------------------
module gcb_blend (
  input  logic          clk_i,
  input  gcb_pkg::rgb_t bg_i,
  input  gcb_pkg::rgb_t pen_i,
  input  logic [7:0]    cov_i,
  output gcb_pkg::rgb_t mix_o
);
  import gcb_pkg::*;

  chan_t       bg  [3];
  chan_t       pen [3];
  chan_t       res [3];
  logic [15:0] sum_d  [3];
  logic [15:0] sum_q  [3];
  logic [15:0] sum2_q [3];
  logic [7:0]  qest_q [3];
  logic [24:0] recip  [3];
  logic [15:0] rem    [3];
  logic [7:0]  inv_h;

  assign bg[0]  = bg_i.r;
  assign bg[1]  = bg_i.g;
  assign bg[2]  = bg_i.b;
  assign pen[0] = pen_i.r;
  assign pen[1] = pen_i.g;
  assign pen[2] = pen_i.b;
  assign inv_h  = 8'd255 - cov_i;

  // Stage 1: weighted sum, at most 255*255
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = ({8'd0, inv_h} * {8'd0, bg[i]}) + ({8'd0, cov_i} * {8'd0, pen[i]});
    end
  end

  // Stage 2: estimate sum/255 as (sum*257)>>16, low by at most one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      recip[i] = {9'd0, sum_q[i]} * 25'd257;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sum_q[i]  <= sum_d[i];
      sum2_q[i] <= sum_q[i];
      qest_q[i] <= recip[i][23:16];
    end
  end

  // Correction: bump the estimate when the remainder reaches 255
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[i] = sum2_q[i] - ({qest_q[i], 8'd0} - {8'd0, qest_q[i]});
      res[i] = qest_q[i] + 8'(rem[i] >= 16'd255);
    end
  end

  assign mix_o = '{r: res[0], g: res[1], b: res[2]};

endmodule
